// ===== design/gpv_pkg.sv =====
// ----------------------------------------------------------------------------
// gpv_pkg: shared types for the position-list block
// Beat payloads, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpv_pkg;

  localparam int VALUE_W          = 8;
  localparam int POS_OUT_W        = 6;
  localparam int DEF_MAX_ELEMENTS = 64;
  localparam int DEF_VALUE_RANGE  = 256;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_last;
  } gpv_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   found_value;
    logic [POS_OUT_W-1:0] position;
    logic                 first_of_value;
    logic                 last_of_run;
  } gpv_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_SCAN,
    ST_HEAD,
    ST_EMIT,
    ST_FOLLOW
  } gpv_state_t;

  typedef struct packed {
    logic accept;
    logic link;
    logic scan;
    logic head;
    logic emit;
    logic follow;
    logic clear;
  } gpv_cmd_t;

  typedef struct packed {
    logic item_last;
    logic scan_end;
    logic hit;
    logic at_tail;
    logic out_free;
  } gpv_sts_t;

endpackage

// ===== design/gpv_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpv_ctrl: sequencer for loading and reporting
// Takes one item, links it into its value's list, and on the last item walks
// the values in ascending order and each list from head to tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpv_ctrl
  import gpv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  gpv_sts_t sts,
  output gpv_cmd_t cmd
);

  gpv_state_t state_r;
  gpv_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LINK;
        end
      end
      ST_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = sts.item_last ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.hit) begin
            state_nxt = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        cmd.head  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.at_tail ? ST_SCAN : ST_FOLLOW;
        end
      end
      ST_FOLLOW: begin
        cmd.follow = 1'b1;
        state_nxt  = ST_EMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/gpv_dpath.sv =====
// ----------------------------------------------------------------------------
// gpv_dpath: position-list tables and result register
// Each nonzero value keeps a linked list of its positions: head and tail
// tables indexed by value, and a next-pointer memory indexed by position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpv_dpath
  import gpv_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int VALUE_RANGE  = DEF_VALUE_RANGE
) (
  input  logic     clk,
  input  logic     rst_n,
  input  gpv_in_t  in_data,
  input  logic     out_ready,
  output logic     out_valid,
  output gpv_out_t out_data,
  input  gpv_cmd_t cmd,
  output gpv_sts_t sts
);

  localparam int TBL_DEPTH = (VALUE_RANGE > 2**VALUE_W) ? 2**VALUE_W : VALUE_RANGE;
  localparam int TBL_W     = $clog2(TBL_DEPTH);
  localparam int VIDX_W    = TBL_W + 1;
  localparam int POS_W     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);

  logic [POS_W-1:0] head_mem [TBL_DEPTH];
  logic [POS_W-1:0] tail_mem [TBL_DEPTH];
  logic [POS_W-1:0] next_mem [MAX_ELEMENTS];

  logic [TBL_DEPTH-1:0] present_r;
  logic [CNT_W-1:0]     count_r;
  logic [TBL_W-1:0]     max_r;
  logic [VIDX_W-1:0]    v_r;

  logic [TBL_W-1:0] item_idx_r;
  logic             item_ok_r;
  logic             item_nz_r;
  logic             item_last_r;

  logic [POS_W-1:0] head_rd_r;
  logic [POS_W-1:0] tail_rd_r;
  logic [POS_W-1:0] next_rd_r;
  logic [POS_W-1:0] p_r;
  logic [POS_W-1:0] tail_v_r;
  logic             first_r;

  logic             out_valid_r;
  gpv_out_t         out_r;

  logic             rd_en;
  logic [TBL_W-1:0] rd_addr;
  logic [POS_W-1:0] item_pos;
  logic             do_link;
  logic             at_tail;

  assign rd_en    = cmd.accept | cmd.scan;
  assign rd_addr  = cmd.scan ? v_r[TBL_W-1:0] : in_data.value[TBL_W-1:0];
  assign item_pos = count_r[POS_W-1:0];
  assign do_link  = cmd.link & item_ok_r & item_nz_r;
  assign at_tail  = (p_r == tail_v_r);

  assign sts.item_last = item_last_r;
  assign sts.scan_end  = (v_r > {1'b0, max_r});
  assign sts.hit       = present_r[v_r[TBL_W-1:0]];
  assign sts.at_tail   = at_tail;
  assign sts.out_free  = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_idx_r  <= in_data.value[TBL_W-1:0];
      item_ok_r   <= (32'(in_data.value) < 32'(VALUE_RANGE)) &&
                     (count_r < CNT_W'(MAX_ELEMENTS));
      item_nz_r   <= (in_data.value != '0);
      item_last_r <= in_data.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (do_link) begin
      tail_mem[item_idx_r] <= item_pos;
      if (!present_r[item_idx_r]) begin
        head_mem[item_idx_r] <= item_pos;
      end
    end
    if (rd_en) begin
      head_rd_r <= head_mem[rd_addr];
      tail_rd_r <= tail_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_link && present_r[item_idx_r]) begin
      next_mem[tail_rd_r] <= item_pos;
    end
    if (cmd.emit) begin
      next_rd_r <= next_mem[p_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      count_r   <= '0;
      max_r     <= '0;
      v_r       <= VIDX_W'(1);
    end else if (cmd.clear) begin
      present_r <= '0;
      count_r   <= '0;
      max_r     <= '0;
      v_r       <= VIDX_W'(1);
    end else begin
      if (cmd.link && item_ok_r) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (do_link) begin
        present_r[item_idx_r] <= 1'b1;
        if (item_idx_r > max_r) begin
          max_r <= item_idx_r;
        end
      end
      if ((cmd.scan && !sts.hit) || (cmd.emit && at_tail)) begin
        v_r <= v_r + VIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head) begin
      p_r      <= head_rd_r;
      tail_v_r <= tail_rd_r;
      first_r  <= 1'b1;
    end else if (cmd.follow) begin
      p_r <= next_rd_r;
    end
    if (cmd.emit) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.found_value    <= VALUE_W'(v_r);
      out_r.position       <= POS_OUT_W'(p_r);
      out_r.first_of_value <= first_r;
      out_r.last_of_run    <= at_tail && (v_r[TBL_W-1:0] == max_r);
    end
  end

endmodule

// ===== design/group_positions_by_value_core.sv =====
// ----------------------------------------------------------------------------
// group_positions_by_value_core: report of positions grouped by value
// Each input beat is accepted in the idle state and linked in the link state;
// the next beat is taken right after. After the last beat the report scans
// values upward from 1 to the largest, with head and follow steps set by the
// registered reads of the head, tail and next-pointer memories.
// Reset clears control state and presence bits directly; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module group_positions_by_value_core
  import gpv_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int VALUE_RANGE  = DEF_VALUE_RANGE
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  gpv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output gpv_out_t out_data
);

  gpv_cmd_t cmd;
  gpv_sts_t sts;

  gpv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpv_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_RANGE  (VALUE_RANGE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("Result beat loaded while the output register was still full.");

  a_link_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.link)
    else $error("Accepted beat was not linked in the following cycle.");

  a_clear_final: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (!out_valid || out_data.last_of_run))
    else $error("Report ended with a pending beat that is not the final one.");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for group_positions_by_value_core
// Feeds lists of values and checks every reported position against a local
// model of the position lists. A short table of directed lists comes first,
// followed by random lists. Both handshakes are paced at random, with one long
// receiver hold that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gpv_pkg::*;

  localparam int LIST_CAP    = DEF_MAX_ELEMENTS;
  localparam int VALUE_SPAN  = DEF_VALUE_RANGE;
  localparam int TARGET_BEATS = 360;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_SOLO
  } row_kind_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic                 is_last;
    row_kind_t            kind;
    logic [VALUE_W-1:0]   want_value;
    logic [POS_OUT_W-1:0] want_pos;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [22] = '{
    '{8'd0,   1'b1, ROW_NONE,    8'd0,   6'd0},
    '{8'd255, 1'b1, ROW_SOLO,    8'd255, 6'd0},
    '{8'd1,   1'b1, ROW_SOLO,    8'd1,   6'd0},
    '{8'd0,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd0,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd128, 1'b1, ROW_SOLO,    8'd128, 6'd2},
    '{8'd5,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd3,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd5,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd0,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd3,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd170, 1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd85,  1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd255, 1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd1,   1'b1, ROW_PREDICT, 8'd0,   6'd0},
    '{8'd200, 1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd100, 1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd200, 1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd100, 1'b1, ROW_PREDICT, 8'd0,   6'd0},
    '{8'd0,   1'b0, ROW_NONE,    8'd0,   6'd0},
    '{8'd0,   1'b1, ROW_NONE,    8'd0,   6'd0},
    '{8'd254, 1'b1, ROW_SOLO,    8'd254, 6'd0}
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  gpv_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  gpv_out_t out_data;

  logic [VALUE_W-1:0] listed_vals [LIST_CAP];
  int unsigned        listed_count;
  gpv_out_t           expected_hits [$];
  int unsigned        mismatches;
  int unsigned        beats_sent;
  int unsigned        burst_left;

  group_positions_by_value_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Records one accepted value and, on the last beat of a list, builds the
  // grouped position report and clears the list.
  function automatic void file_value(input gpv_in_t b, input bit keep);
    gpv_out_t run [$];
    gpv_out_t hit;
    bit       first;
    if (listed_count < LIST_CAP) begin
      listed_vals[listed_count] = b.value;
      listed_count++;
    end
    if (b.is_last) begin
      for (int v = 1; v < VALUE_SPAN; v++) begin
        first = 1'b1;
        for (int p = 0; p < listed_count; p++) begin
          if (listed_vals[p] == v[VALUE_W-1:0]) begin
            hit.found_value    = v[VALUE_W-1:0];
            hit.position       = p[POS_OUT_W-1:0];
            hit.first_of_value = first;
            hit.last_of_run    = 1'b0;
            first = 1'b0;
            run.push_back(hit);
          end
        end
      end
      if (run.size() > 0) begin
        run[run.size()-1].last_of_run = 1'b1;
      end
      if (keep) begin
        foreach (run[i]) expected_hits.push_back(run[i]);
      end
      listed_count = 0;
    end
  endfunction

  task automatic send_beat(input gpv_in_t b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_random_list(input int unsigned len, input int unsigned style);
    gpv_in_t            b;
    logic [VALUE_W-1:0] palette [3];
    foreach (palette[i]) palette[i] = VALUE_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (style)
        0: b.value = VALUE_W'($urandom_range(0, 255));
        1: b.value = VALUE_W'($urandom_range(0, 7));
        2: b.value = ($urandom_range(0, 3) == 0) ? 8'd0 : palette[$urandom_range(0, 2)];
        3: b.value = VALUE_W'($urandom_range(248, 255));
        default: b.value = '0;
      endcase
      b.is_last = (i == len - 1);
      send_beat(b);
      file_value(b, 1'b1);
    end
  endtask

  // Receiver: one long hold once the input is busy, then stall patterns.
  initial begin
    int unsigned stall_mode;
    bit          held_off;
    held_off  = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && beats_sent >= 40) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      stall_mode = $urandom_range(0, 2);
      repeat ($urandom_range(8, 48)) begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    gpv_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: value %0d pos %0d first %0b last %0b",
                   out_data.found_value, out_data.position,
                   out_data.first_of_value, out_data.last_of_run);
        end
      end else begin
        want = expected_hits.pop_front();
        if (out_data.found_value !== want.found_value ||
            out_data.position !== want.position ||
            out_data.first_of_value !== want.first_of_value ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: got %0d pos %0d first %0b last %0b, expected %0d %0d %0b %0b",
                     out_data.found_value, out_data.position,
                     out_data.first_of_value, out_data.last_of_run,
                     want.found_value, want.position,
                     want.first_of_value, want.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    gpv_in_t     b;
    gpv_out_t    solo;
    int unsigned list_idx;
    int unsigned len;
    int unsigned pick;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    listed_count = 0;
    mismatches   = 0;
    beats_sent   = 0;
    burst_left   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      b.value   = DIR_ROWS[i].value;
      b.is_last = DIR_ROWS[i].is_last;
      send_beat(b);
      file_value(b, DIR_ROWS[i].kind == ROW_PREDICT);
      if (DIR_ROWS[i].kind == ROW_SOLO) begin
        solo.found_value    = DIR_ROWS[i].want_value;
        solo.position       = DIR_ROWS[i].want_pos;
        solo.first_of_value = 1'b1;
        solo.last_of_run    = 1'b1;
        expected_hits.push_back(solo);
      end
    end

    // The third list overflows the table with its last beat past capacity,
    // and the sixth fills it exactly.
    list_idx = 0;
    while (beats_sent < TARGET_BEATS) begin
      pick = $urandom_range(0, 19);
      if (list_idx == 2) begin
        len = LIST_CAP + 2;
      end else if (list_idx == 5) begin
        len = LIST_CAP;
      end else if (pick < 2) begin
        len = $urandom_range(20, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      if (pick >= 17) begin
        send_random_list(len, 4);
      end else begin
        send_random_list(len, $urandom_range(0, 3));
      end
      list_idx++;
    end

    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gpv_pkg.sv
design/gpv_ctrl.sv
design/gpv_dpath.sv
design/group_positions_by_value_core.sv
dv/tb.sv
